// File: hdl/srg_pkg.sv
// Shared types and constants for the seeded region grow block.
// No dependencies; every other file but srg_ram imports this package.
package srg_pkg;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 17;
    localparam int CH_W      = 8;
    localparam int COLOUR_W  = 3 * CH_W;
    localparam int SQ_W      = 2 * CH_W;
    localparam int SUM_W     = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_ROW       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_COL       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_LOW        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_HIGH       = 3'd6;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_GROW = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]      opcode;
        logic [CH_W-1:0] pixel_row;
        logic [CH_W-1:0] pixel_col;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] hue;
    } t_in;

    typedef struct packed {
        logic             in_region;
        logic [CH_W-1:0]  out_blue;
        logic [CH_W-1:0]  out_green;
        logic [CH_W-1:0]  out_red;
        logic [CNT_W-1:0] region_count;
    } t_out;

    typedef struct packed {
        logic [8:0] image_rows;
        logic [8:0] image_cols;
        logic [7:0] seed_row;
        logic [7:0] seed_col;
        logic [8:0] distance_limit;
        logic [7:0] hue_low;
        logic [8:0] hue_high;
    } t_cfg;

    // Classified command handed from the front queue to the engine.
    typedef struct packed {
        t_op  op;
        logic in_range;
        t_in  item;
    } t_cmd;

    typedef struct packed {
        logic init_done;
    } t_eng_stat;

endpackage

// File: hdl/seeded_region_grow.sv
// A load or stray word can be popped once the engine takes it; a readout waits on the
// registered mask read. The engine takes no new command until the last result is popped.
// Grow: the engine takes the command, sweeps all 2**(RW+CW) mask words clear (65536 at
// defaults), fetches the seed, then pops each pixel and checks its in-image neighbors,
// ending when the stack is empty; the single memory ports serialise the steps.
// Reset (synchronous, active low) starts the same mask sweep with full high; registers
// return to 256,256,0,0,0,0,256.
module seeded_region_grow
    import srg_pkg::*;
#(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input word queue
    input  logic                 push,
    output logic                 full,
    input  t_in                  i_in,
    // result word queue
    output logic                 empty,
    input  logic                 pop,
    output t_out                 o_out,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    t_cfg      r_cfg;
    t_cmd      w_cmd;
    logic      w_cmd_valid;
    logic      w_cmd_ready;
    t_eng_stat w_stat;

    // Hold the register file; drop writes to unknown indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{image_rows: 9'd256, image_cols: 9'd256, seed_row: '0,
                       seed_col: '0, distance_limit: '0, hue_low: '0,
                       hue_high: 9'd256};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_ROWS:     r_cfg.image_rows     <= i_cfg_wdata;
                CFG_IMAGE_COLS:     r_cfg.image_cols     <= i_cfg_wdata;
                CFG_SEED_ROW:       r_cfg.seed_row       <= i_cfg_wdata[7:0];
                CFG_SEED_COL:       r_cfg.seed_col       <= i_cfg_wdata[7:0];
                CFG_DISTANCE_LIMIT: r_cfg.distance_limit <= i_cfg_wdata;
                CFG_HUE_LOW:        r_cfg.hue_low        <= i_cfg_wdata[7:0];
                CFG_HUE_HIGH:       r_cfg.hue_high       <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Front: classify words and buffer them so the engine can stall alone.
    srg_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_in),
        .i_stat      (w_stat),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    // Back: run commands, flood with the pending stack, hold the result word.
    srg_engine #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );

endmodule

// File: hdl/srg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/srg_front.sv
// Front end: two-word input queue that decodes the opcode and range-checks
// the pixel position. Depends on srg_pkg.
module srg_front
    import srg_pkg::*;
#(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    output logic      o_full,
    input  t_in       i_item,
    input  t_eng_stat i_stat,
    output logic      o_cmd_valid,
    input  logic      i_cmd_ready,
    output t_cmd      o_cmd
);

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CMW = ((RW > CW) ? RW : CW) + 2;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wr;
    logic       n_rd;
    t_cmd       n_cmd;

    always_comb begin
        n_cmd.item = i_item;
        n_cmd.in_range = (CMW'(i_item.pixel_row) < CMW'(MAX_ROWS))
                      && (CMW'(i_item.pixel_col) < CMW'(MAX_COLS));
        case (i_item.opcode)
            OP_LOAD: n_cmd.op = OP_LOAD;
            OP_GROW: n_cmd.op = OP_GROW;
            OP_READ: n_cmd.op = OP_READ;
            default: n_cmd.op = OP_NONE;
        endcase
    end

    assign o_full      = (r_cnt == 2'd2) || !i_stat.init_done;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign n_wr        = i_push && !o_full;
    assign n_rd        = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (n_wr) begin
                r_wp <= !r_wp;
            end
            if (n_rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, n_wr} - {1'b0, n_rd};
        end
    end

endmodule

// File: hdl/srg_engine.sv
// Back end: executes load, read and grow commands against the pixel, mask
// and stack memories. Depends on srg_pkg and srg_ram.
module srg_engine
    import srg_pkg::*;
#(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cmd      i_cmd,
    output t_eng_stat o_stat,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out      o_out
);

    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW     = RW + CW;
    localparam int IMG_D  = 1 << AW;
    localparam int PIXELS = MAX_ROWS * MAX_COLS;
    localparam int SAW    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int TW     = $clog2(PIXELS + 1);
    localparam int MW     = (RW > CW) ? RW : CW;
    localparam int RSW    = (MW + 1 > 9) ? MW + 1 : 9;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RD_WAIT, S_CLEAR, S_SEED_RD, S_SEED_WAIT,
        S_POP, S_POP_WAIT, S_N_RD, S_N_SQ, S_N_DEC
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_clr;
    logic [RSW-1:0]      r_rows;
    logic [RSW-1:0]      r_cols;
    logic [SUM_W-1:0]    r_lim_sq;
    logic [COLOUR_W-1:0] r_seed;
    logic [TW-1:0]       r_top;
    logic [CNT_W-1:0]    r_count;
    logic [RW-1:0]       r_pr;
    logic [CW-1:0]       r_pc;
    logic [1:0]          r_du;
    logic [1:0]          r_dv;
    logic [RW-1:0]       r_nr;
    logic [CW-1:0]       r_nc;
    logic [SQ_W-1:0]     r_sq [3];
    logic                r_hue_ok;
    logic                r_unmarked;
    logic                r_out_valid;
    t_out                r_out;

    logic [RW:0]         n_nr;
    logic [CW:0]         n_nc;
    logic                n_nb_ok;
    logic                n_last_nb;
    logic [AW-1:0]       n_item_addr;
    logic [AW-1:0]       n_seed_addr;
    logic [AW-1:0]       n_raddr;
    logic                n_seed_in;
    logic [SUM_W-1:0]    n_sum;
    logic                n_join;
    logic [CH_W-1:0]     n_diff [3];
    logic [RSW-1:0]      n_rows;
    logic [RSW-1:0]      n_cols;

    logic                n_img_we;
    logic                n_mask_we;
    logic [AW-1:0]       n_mask_waddr;
    logic                n_mask_wdata;
    logic                n_stk_we;
    logic [SAW-1:0]      n_stk_raddr;
    logic [COLOUR_W-1:0] w_colour;
    logic [CH_W-1:0]     w_hue;
    logic                w_mask;
    logic [AW-1:0]       w_stk;

    // Address and neighbor arithmetic
    always_comb begin
        n_item_addr = {RW'(i_cmd.item.pixel_row), CW'(i_cmd.item.pixel_col)};
        n_seed_addr = {RW'(i_cfg.seed_row), CW'(i_cfg.seed_col)};
        n_seed_in   = (RSW'(i_cfg.seed_row) < r_rows) && (RSW'(i_cfg.seed_col) < r_cols);
        n_nr = (RW + 1)'(r_pr) + (RW + 1)'(r_du) - (RW + 1)'(1);
        n_nc = (CW + 1)'(r_pc) + (CW + 1)'(r_dv) - (CW + 1)'(1);
        n_nb_ok = !((r_du == 2'd0) && (r_pr == '0))
               && !((r_dv == 2'd0) && (r_pc == '0))
               && (RSW'(n_nr) < r_rows) && (RSW'(n_nc) < r_cols);
        n_last_nb = (r_du == 2'd2) && (r_dv == 2'd2);
        case (r_state)
            S_IDLE:    n_raddr = n_item_addr;
            S_SEED_RD: n_raddr = n_seed_addr;
            default:   n_raddr = {n_nr[RW-1:0], n_nc[CW-1:0]};
        endcase
        for (int k = 0; k < 3; k++) begin
            n_diff[k] = (w_colour[k*CH_W +: CH_W] > r_seed[k*CH_W +: CH_W])
                      ? w_colour[k*CH_W +: CH_W] - r_seed[k*CH_W +: CH_W]
                      : r_seed[k*CH_W +: CH_W] - w_colour[k*CH_W +: CH_W];
        end
        n_sum  = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
        n_join = r_unmarked && r_hue_ok && (n_sum < r_lim_sq) && (r_top < TW'(PIXELS));
        n_rows = (i_cfg.image_rows == '0) ? RSW'(1)
               : ((RSW'(i_cfg.image_rows) > RSW'(MAX_ROWS)) ? RSW'(MAX_ROWS)
               : RSW'(i_cfg.image_rows));
        n_cols = (i_cfg.image_cols == '0) ? RSW'(1)
               : ((RSW'(i_cfg.image_cols) > RSW'(MAX_COLS)) ? RSW'(MAX_COLS)
               : RSW'(i_cfg.image_cols));
    end

    // Memory control
    always_comb begin
        o_cmd_ready  = (r_state == S_IDLE) && !r_out_valid;
        n_img_we     = o_cmd_ready && i_cmd_valid && (i_cmd.op == OP_LOAD) && i_cmd.in_range;
        n_mask_we    = (r_state == S_INIT) || (r_state == S_CLEAR)
                    || ((r_state == S_N_DEC) && n_join);
        n_mask_waddr = ((r_state == S_INIT) || (r_state == S_CLEAR)) ? r_clr : {r_nr, r_nc};
        n_mask_wdata = (r_state == S_N_DEC);
        n_stk_we     = (r_state == S_SEED_WAIT) || ((r_state == S_N_DEC) && n_join);
        n_stk_raddr  = SAW'(r_top - TW'(1));
    end

    srg_ram #(.WIDTH(COLOUR_W), .DEPTH(IMG_D)) u_colour (
        .i_clk   (i_clk),
        .i_we    (n_img_we),
        .i_waddr (n_item_addr),
        .i_wdata ({i_cmd.item.red, i_cmd.item.green, i_cmd.item.blue}),
        .i_raddr (n_raddr),
        .o_rdata (w_colour)
    );

    srg_ram #(.WIDTH(CH_W), .DEPTH(IMG_D)) u_hue (
        .i_clk   (i_clk),
        .i_we    (n_img_we),
        .i_waddr (n_item_addr),
        .i_wdata (i_cmd.item.hue),
        .i_raddr (n_raddr),
        .o_rdata (w_hue)
    );

    srg_ram #(.WIDTH(1), .DEPTH(IMG_D)) u_mask (
        .i_clk   (i_clk),
        .i_we    (n_mask_we),
        .i_waddr (n_mask_waddr),
        .i_wdata (n_mask_wdata),
        .i_raddr (n_raddr),
        .o_rdata (w_mask)
    );

    srg_ram #(.WIDTH(AW), .DEPTH(PIXELS)) u_stack (
        .i_clk   (i_clk),
        .i_we    (n_stk_we),
        .i_waddr (SAW'(r_top)),
        .i_wdata ((r_state == S_SEED_WAIT) ? n_seed_addr : {r_nr, r_nc}),
        .i_raddr (n_stk_raddr),
        .o_rdata (w_stk)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr       <= '0;
            r_top       <= '0;
            r_count     <= '0;
            r_seed      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_cmd_ready && i_cmd_valid) begin
                        r_out <= '{in_region: 1'b0, out_blue: '0, out_green: '0,
                                   out_red: '0, region_count: r_count};
                        case (i_cmd.op)
                            OP_READ: begin
                                if (i_cmd.in_range) begin
                                    r_state <= S_RD_WAIT;
                                end else begin
                                    r_out_valid <= 1'b1;
                                end
                            end
                            OP_GROW: begin
                                r_rows   <= n_rows;
                                r_cols   <= n_cols;
                                r_lim_sq <= SUM_W'(i_cfg.distance_limit * i_cfg.distance_limit);
                                r_count  <= '0;
                                r_top    <= '0;
                                r_clr    <= '0;
                                r_state  <= S_CLEAR;
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RD_WAIT: begin
                    r_out.in_region <= w_mask;
                    r_out.out_blue  <= w_mask ? r_seed[0 +: CH_W] : '0;
                    r_out.out_green <= w_mask ? r_seed[CH_W +: CH_W] : '0;
                    r_out.out_red   <= w_mask ? r_seed[2*CH_W +: CH_W] : '0;
                    r_out_valid     <= 1'b1;
                    r_state         <= S_IDLE;
                end
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == '1) begin
                        if (n_seed_in) begin
                            r_state <= S_SEED_RD;
                        end else begin
                            r_out.region_count <= '0;
                            r_out_valid        <= 1'b1;
                            r_state            <= S_IDLE;
                        end
                    end
                end
                S_SEED_RD: begin
                    r_state <= S_SEED_WAIT;
                end
                S_SEED_WAIT: begin
                    r_seed  <= w_colour;
                    r_top   <= TW'(1);
                    r_state <= S_POP;
                end
                S_POP: begin
                    if (r_top == '0) begin
                        r_out.region_count <= r_count;
                        r_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end else begin
                        r_top   <= r_top - TW'(1);
                        r_state <= S_POP_WAIT;
                    end
                end
                S_POP_WAIT: begin
                    r_pr    <= w_stk[AW-1:CW];
                    r_pc    <= w_stk[CW-1:0];
                    r_du    <= 2'd0;
                    r_dv    <= 2'd0;
                    r_state <= S_N_RD;
                end
                S_N_RD: begin
                    r_nr <= n_nr[RW-1:0];
                    r_nc <= n_nc[CW-1:0];
                    if (n_nb_ok) begin
                        r_state <= S_N_SQ;
                    end else if (n_last_nb) begin
                        r_state <= S_POP;
                    end else begin
                        r_du <= (r_dv == 2'd2) ? r_du + 2'd1 : r_du;
                        r_dv <= (r_dv == 2'd2) ? 2'd0 : r_dv + 2'd1;
                    end
                end
                S_N_SQ: begin
                    for (int k = 0; k < 3; k++) begin
                        r_sq[k] <= SQ_W'(n_diff[k] * n_diff[k]);
                    end
                    r_hue_ok   <= (w_hue >= i_cfg.hue_low) && ({1'b0, w_hue} < i_cfg.hue_high);
                    r_unmarked <= !w_mask;
                    r_state    <= S_N_DEC;
                end
                S_N_DEC: begin
                    if (n_join) begin
                        r_top   <= r_top + TW'(1);
                        r_count <= r_count + CNT_W'(1);
                    end
                    if (n_last_nb) begin
                        r_state <= S_POP;
                    end else begin
                        r_du    <= (r_dv == 2'd2) ? r_du + 2'd1 : r_du;
                        r_dv    <= (r_dv == 2'd2) ? 2'd0 : r_dv + 2'd1;
                        r_state <= S_N_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat.init_done = (r_state != S_INIT);
    assign o_empty          = !r_out_valid;
    assign o_out            = r_out;

endmodule

// File: hdl/srg_checker.sv
// Port-level checks for seeded_region_grow, attached with a bind.
// Depends on srg_pkg.
module srg_checker
    import srg_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic full,
    input logic empty,
    input logic pop,
    input t_out o_out
);

    a_full_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("full low right after reset");

    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    a_nonmember_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out.in_region) |->
        (o_out.out_blue == '0 && o_out.out_green == '0 && o_out.out_red == '0))
        else $error("non-member result carries colour");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out)))
        else $error("waiting result changed");

endmodule

bind seeded_region_grow srg_checker u_srg_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_out   (o_out)
);
